/* hdl/isort_pkg.sv */
// Shared types for the insertion sorter: element word and per-cell control.
package isort_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic ins;    // insert the broadcast key this cycle
    logic shift;  // drain: take the right neighbor's entry
  } cell_ctrl_t;

endpackage

/* hdl/isort_cell.sv */
// One cell of the insertion chain: holds one sorted entry.
module isort_cell (
  input  logic                clk,
  input  isort_pkg::cell_ctrl_t ctrl,
  input  isort_pkg::value_t   key,
  input  logic                occupied,
  input  logic                left_occupied,
  input  logic                left_gt,
  input  isort_pkg::value_t   left_value,
  input  isort_pkg::value_t   right_value,
  output isort_pkg::value_t   value,
  output logic                gt
);
  import isort_pkg::*;

  value_t value_next;
  logic   take;

  // Strict compare: equal keys stay behind earlier arrivals.
  assign gt   = occupied && (value > key);
  // Shift up when larger, or fill the first free slot.
  assign take = gt || (!occupied && left_occupied);

  always_comb begin
    value_next = value;
    if (ctrl.shift) begin
      value_next = right_value;
    end else if (ctrl.ins && take) begin
      value_next = left_gt ? left_value : key;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

/* hdl/insertion_sorter.sv */
// Top level of the insertion sorter: cell chain plus fill/drain sequencer.
//
// Collects a set of signed 32-bit values, one request per cycle while filling, into a
// chain of MAX_ELEMENTS cells that stays sorted ascending at all times: every
// cell compares its entry with the incoming value in parallel, and the larger
// entries move up one cell while the new value drops into the gap. Equal
// values keep arrival order. A request with last set closes the set; the
// chain then drains from cell 0, one result per accepted output cycle, with
// final_res on the last result and dropped set on every result of a set that
// lost values to a full chain. While filling, one request is taken every
// clock. While draining, no input request is taken; the next set may
// start the cycle after the final result is taken. The set size is
// tracked by a fill counter, so entries never written are never read and
// the chain needs no clearing after reset.
module insertion_sorter #(
  parameter int unsigned MAX_ELEMENTS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  isort_pkg::value_t   value,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_ready,
  output isort_pkg::value_t   value_res,
  output logic                final_res,
  output logic                dropped
);
  import isort_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             overflow, overflow_next;

  logic in_fire, out_fire, full;
  cell_ctrl_t ctrl;

  value_t cell_value [MAX_ELEMENTS];
  logic   cell_gt    [MAX_ELEMENTS];
  logic   cell_occ   [MAX_ELEMENTS];

  assign in_ready  = (state == ST_FILL);
  assign out_valid = (state == ST_DRAIN);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign full      = (count == CNT_MAX);

  assign ctrl.ins   = in_fire && !full;
  assign ctrl.shift = out_fire;

  // Chain: cell i sees its left neighbor for inserts, right for draining.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    assign cell_occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_head
      isort_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .key          (value),
        .occupied     (cell_occ[i]),
        .left_occupied(1'b1),
        .left_gt      (1'b0),
        .left_value   (value),
        .right_value  (cell_value[(i + 1) % MAX_ELEMENTS]),
        .value        (cell_value[i]),
        .gt           (cell_gt[i])
      );
    end else begin : g_body
      isort_cell u_cell (
        .clk          (clk),
        .ctrl         (ctrl),
        .key          (value),
        .occupied     (cell_occ[i]),
        .left_occupied(cell_occ[i-1]),
        .left_gt      (cell_gt[i-1]),
        .left_value   (cell_value[i-1]),
        .right_value  (cell_value[(i + 1) % MAX_ELEMENTS]),
        .value        (cell_value[i]),
        .gt           (cell_gt[i])
      );
    end
  end

  // Results come straight off the head cell.
  assign value_res = cell_value[0];
  assign final_res = (count == CNT_ONE);
  assign dropped   = overflow;

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow;
    unique case (state)
      ST_FILL: begin
        if (in_fire) begin
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            count_next = count + CNT_ONE;
          end
          if (last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_next = count - CNT_ONE;
          if (final_res) begin
            state_next    = ST_FILL;
            overflow_next = 1'b0;
          end
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  // A draining chain always holds at least one entry.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0))
    else $error("drain with empty chain");

  // Fill count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("fill count past capacity");

  // Closing request starts the drain on the next cycle.
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (in_fire && last) |=> out_valid)
    else $error("closing request did not start drain");

  // After the final result the chain is empty and open for requests.
  a_final_empties: assert property (@(posedge clk) disable iff (rst)
    (out_fire && final_res) |=> (in_ready && count == '0 && !dropped))
    else $error("chain not emptied after final result");

endmodule
